>>> hw/rtl/dbcr_pkg.sv
// Package for the deadband change reporter: constants, codes and shared types.
`default_nettype none

package dbcr_pkg;

  // Default geometry
  localparam int ANALOG_CHANNELS_DEF = 4;
  localparam int BUTTON_COUNT_DEF    = 16;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int INDEX_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Fixed values
  localparam logic [VALUE_W-1:0] DEADBAND_RESET = 16'd48;
  localparam logic [COUNT_W-1:0] FULL_SCALE     = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENDER = 2'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Operations of the shared unit
  typedef enum logic {
    OP_DEADBAND = 1'b0,
    OP_COUNT    = 1'b1
  } unit_op_t;

  // Request to the shared unit
  typedef struct packed {
    unit_op_t             op;
    logic [VALUE_W-1:0]   opa;
    logic [VALUE_W-1:0]   opb;
    logic [VALUE_W-1:0]   deadband;
  } unit_req_t;

  // Result of the shared unit
  typedef struct packed {
    logic                 exceeds;
    logic [COUNT_W-1:0]   incr;
  } unit_rsp_t;

  // One report item
  typedef struct packed {
    logic                 is_button;
    logic [INDEX_W-1:0]   index;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   count;
  } report_t;

endpackage

`default_nettype wire

>>> hw/rtl/dbcr_unit.sv
// Shared arithmetic unit: deadband compare for analog channels, count increment for buttons.
`default_nettype none

module dbcr_unit
  import dbcr_pkg::*;
(
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  logic [VALUE_W:0] sum_ab;
  logic [VALUE_W:0] sum_ba;
  logic [VALUE_W:0] add_b;

  // Shared adder: opb + deadband for the compare, opa + 1 for the count
  always_comb begin
    if (req.op == OP_COUNT) begin
      add_b  = {1'b0, req.opa};
      sum_ab = add_b + {{VALUE_W{1'b0}}, 1'b1};
    end else begin
      add_b  = {1'b0, req.opb};
      sum_ab = add_b + {1'b0, req.deadband};
    end
  end

  // Mirror sum for the other sign of the difference
  assign sum_ba = {1'b0, req.opa} + {1'b0, req.deadband};

  // |opa - opb| > deadband  <=>  opa > opb + db  or  opb > opa + db
  assign rsp.exceeds = ({1'b0, req.opa} > sum_ab) || ({1'b0, req.opb} > sum_ba);
  assign rsp.incr    = sum_ab[COUNT_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/deadband_change_reporter.sv
// Top level of the deadband change reporter: sequencer, held state and output register.
//
// Each accepted poll is walked one element per cycle, the analog channels
// first, then (with the extender enabled) the buttons, all through one shared
// add/compare unit; a reporting step waits while the pending report cannot
// move out past a stalled output. The sequencer goes from idle through the
// scan and flush states back to idle, and in_stall is high while it is out of
// idle. Reports are held one step in a pending register so the final one can
// carry last_report; a poll with nothing to report gives no item.
// Configuration is taken in any cycle (cfg_ready is always high) and
// must only be written while no poll is in progress.
`default_nettype none

module deadband_change_reporter
  import dbcr_pkg::*;
#(
  parameter int ANALOG_CHANNELS = ANALOG_CHANNELS_DEF,
  parameter int BUTTON_COUNT    = BUTTON_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // poll input
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_W-1:0]    in_sample_0,
  input  wire logic [SAMPLE_W-1:0]    in_sample_1,
  input  wire logic [SAMPLE_W-1:0]    in_sample_2,
  input  wire logic [SAMPLE_W-1:0]    in_sample_3,
  input  wire logic [15:0]            in_button_word,
  input  wire logic                   in_force_resync,
  // reports
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_is_button,
  output logic [INDEX_W-1:0]          out_report_index,
  output logic [VALUE_W-1:0]          out_report_value,
  output logic [COUNT_W-1:0]          out_transitions,
  output logic                        out_last_report
);

  localparam int ELEM_N = ANALOG_CHANNELS + BUTTON_COUNT;
  localparam int ELEM_W = $clog2(ELEM_N + 1);
  localparam int CH_IW  = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
  localparam int BTN_IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [ELEM_W-1:0] AN_CNT   = ELEM_W'(ANALOG_CHANNELS);
  localparam logic [ELEM_W-1:0] AN_LAST  = ELEM_W'(ANALOG_CHANNELS - 1);
  localparam logic [ELEM_W-1:0] ALL_LAST = ELEM_W'(ELEM_N - 1);

  // Configuration registers
  logic [VALUE_W-1:0]       deadband_r;
  logic                     extender_r;

  // Sequencer
  state_t                   state_r, state_nxt;
  logic [ELEM_W-1:0]        pos_r, pos_nxt;
  logic [ELEM_W-1:0]        last_pos_r;

  // Latched poll
  logic [VALUE_W-1:0]       scaled_r [ANALOG_CHANNELS];
  logic [BUTTON_COUNT-1:0]  pressed_r;
  logic                     resync_r;

  // Held state
  logic [VALUE_W-1:0]       analog_held_r [ANALOG_CHANNELS];
  logic [BUTTON_COUNT-1:0]  button_held_r;
  logic [COUNT_W-1:0]       button_flips_r [BUTTON_COUNT];

  // Pending and output reports
  report_t                  pend_r;
  logic                     pend_v_r;
  report_t                  out_r;
  logic                     out_last_r;
  logic                     out_valid_r;

  // Step signals
  logic [SAMPLE_W-1:0]      sample_in [4];
  logic                     in_acc;
  logic                     out_free;
  logic                     is_analog;
  logic [CH_IW-1:0]         ch;
  logic [ELEM_W-1:0]        btn_off;
  logic [BTN_IW-1:0]        bi;
  logic                     btn_pressed;
  logic                     btn_changed;
  logic                     hit;
  logic                     step_go;
  logic                     step_end;
  logic                     flush_go;
  report_t                  rep;
  unit_req_t                ureq;
  unit_rsp_t                ursp;

  assign sample_in[0] = in_sample_0;
  assign sample_in[1] = in_sample_1;
  assign sample_in[2] = in_sample_2;
  assign sample_in[3] = in_sample_3;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Decode the current element
  assign is_analog   = (pos_r < AN_CNT);
  assign ch          = pos_r[CH_IW-1:0];
  assign btn_off     = pos_r - AN_CNT;
  assign bi          = btn_off[BTN_IW-1:0];
  assign btn_pressed = pressed_r[bi];
  assign btn_changed = (btn_pressed != button_held_r[bi]);

  // Feed the shared unit
  always_comb begin
    ureq.deadband = deadband_r;
    if (is_analog) begin
      ureq.op  = OP_DEADBAND;
      ureq.opa = scaled_r[ch];
      ureq.opb = analog_held_r[ch];
    end else begin
      ureq.op  = OP_COUNT;
      ureq.opa = button_flips_r[bi];
      ureq.opb = '0;
    end
  end

  dbcr_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  // Form the report of the current element
  always_comb begin
    if (is_analog) begin
      hit           = resync_r || ursp.exceeds;
      rep.is_button = 1'b0;
      rep.index     = INDEX_W'(ch);
      rep.value     = scaled_r[ch];
      rep.count     = FULL_SCALE;
    end else begin
      hit           = resync_r || btn_changed;
      rep.is_button = 1'b1;
      rep.index     = INDEX_W'(bi);
      rep.value     = {{(VALUE_W-1){1'b0}}, btn_pressed};
      rep.count     = btn_changed ? ursp.incr : button_flips_r[bi];
    end
  end

  // A reporting step must push the pending report out first
  assign step_go  = (state_r == ST_SCAN) && (!hit || !pend_v_r || out_free);
  assign step_end = (pos_r == last_pos_r);
  assign flush_go = (state_r == ST_FLUSH) && (!pend_v_r || out_free);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          pos_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (step_go) begin
          pos_nxt = pos_r + 1'b1;
          if (step_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      deadband_r  <= DEADBAND_RESET;
      extender_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEADBAND) begin
          deadband_r <= cfg_data;
        end else if (cfg_index == CFG_EXTENDER) begin
          extender_r <= cfg_data[0];
        end
      end

      // advance pending into the output slot, else drop the output item once taken
      if ((step_go && hit && pend_v_r) || (flush_go && pend_v_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // fill the pending slot on a hit, empty it on the flush
      if (step_go && hit) begin
        pend_v_r <= 1'b1;
      end else if (flush_go && pend_v_r) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // Held state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_held_r <= '0;
      for (int i = 0; i < ANALOG_CHANNELS; i++) begin
        analog_held_r[i] <= '0;
      end
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        button_flips_r[i] <= '0;
      end
    end else if (step_go && hit) begin
      if (is_analog) begin
        analog_held_r[ch] <= scaled_r[ch];
      end else if (btn_changed) begin
        button_held_r[bi]  <= btn_pressed;
        button_flips_r[bi] <= ursp.incr;
      end
    end
  end

  // Payload registers: latch the poll, hold the pending and output items
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < ANALOG_CHANNELS; i++) begin
        // double and clamp: negative to zero, the top never overflows 16 bits
        scaled_r[i] <= sample_in[i][SAMPLE_W-1] ? '0 : {sample_in[i][SAMPLE_W-2:0], 1'b0};
      end
      pressed_r  <= ~in_button_word[BUTTON_COUNT-1:0];
      resync_r   <= in_force_resync;
      last_pos_r <= extender_r ? ALL_LAST : AN_LAST;
    end
    if (step_go && hit) begin
      pend_r <= rep;
      if (pend_v_r) begin
        out_r      <= pend_r;
        out_last_r <= 1'b0;
      end
    end else if (flush_go && pend_v_r) begin
      out_r      <= pend_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_button    = out_r.is_button;
  assign out_report_index = out_r.index;
  assign out_report_value = out_r.value;
  assign out_transitions  = out_r.count;
  assign out_last_report  = out_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/dbcr_checker.sv
// Port-level checks for the deadband change reporter, bound to the top level.
`default_nettype none

module dbcr_checker
  import dbcr_pkg::*;
#(
  parameter int ANALOG_CHANNELS = ANALOG_CHANNELS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_is_button,
  input wire logic [INDEX_W-1:0]   out_report_index,
  input wire logic [VALUE_W-1:0]   out_report_value,
  input wire logic [COUNT_W-1:0]   out_transitions,
  input wire logic                 out_last_report
);

  localparam logic [INDEX_W-1:0] AN_CNT = INDEX_W'(ANALOG_CHANNELS);

  // A stalled report holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_index)
      && $stable(out_report_value) && $stable(out_transitions)
      && $stable(out_last_report) && $stable(out_is_button))
    else $error("stalled report changed");

  // An accepted poll keeps the input side busy
  a_busy_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("poll accepted without going busy");

  // Analog reports name a real channel and carry the full-scale count
  a_analog_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_button |-> out_report_index < AN_CNT
      && out_transitions == FULL_SCALE)
    else $error("malformed analog report");

  // Button reports carry a single pressed bit
  a_button_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_button |-> out_report_value[VALUE_W-1:1] == '0)
    else $error("button report value wider than one bit");

endmodule

bind deadband_change_reporter dbcr_checker #(
  .ANALOG_CHANNELS (ANALOG_CHANNELS)
) u_dbcr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_is_button    (out_is_button),
  .out_report_index (out_report_index),
  .out_report_value (out_report_value),
  .out_transitions  (out_transitions),
  .out_last_report  (out_last_report)
);

`default_nettype wire
